/* rtl/core/swam_pkg.sv */
// ----------------------------------------------------------------------------
// swam_pkg: shared types and constants for the anagram window matcher
// Request and response payloads, op and status codes, and default sizes.
// ----------------------------------------------------------------------------
package swam_pkg;

   // default sizes for the top-level parameters
   localparam int MAX_PATTERN_DEF = 256;
   localparam int ALPHABET_DEF    = 26;

   // fixed field widths
   localparam int LETTER_W = 5;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_PATTERN = 2'd1,
      OP_TEXT    = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_FULL       = 2'd1,
      ST_AFTER_TEXT = 2'd2
   } status_type;

   typedef struct packed {
      op_type              op;
      logic [LETTER_W-1:0] letter;
   } req_type;

   typedef struct packed {
      logic       window_match;
      logic       found;
      status_type status;
   } rsp_type;

endpackage

/* rtl/core/swam_ram.sv */
// ----------------------------------------------------------------------------
// swam_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered (read-first).
// ----------------------------------------------------------------------------
module swam_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/sliding_window_anagram_matcher.sv */
// ----------------------------------------------------------------------------
// sliding_window_anagram_matcher: sliding-window permutation matcher
// A request updates the state and stage two; stage two then loads the response register.
// Throughput: one request per cycle while stage two is empty or can advance; the histogram
//   update and the ring read for the next text letter both complete in the accepting cycle.
// Reset clears all counters, lengths, the ring pointer and the found flag.
// The ring store is not cleared; only entries written since a clear are read.
// ----------------------------------------------------------------------------
module sliding_window_anagram_matcher #(
   parameter int MAX_PATTERN = swam_pkg::MAX_PATTERN_DEF,
   parameter int ALPHABET    = swam_pkg::ALPHABET_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  swam_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output swam_pkg::rsp_type rsp_payload
);

   localparam int NBINS   = ALPHABET + 1;
   localparam int BIN_W   = $clog2(NBINS);
   localparam int CNT_W   = $clog2(MAX_PATTERN + 1);
   localparam int RING_AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   // state registers
   logic [CNT_W-1:0]   pcnt_ff [NBINS];
   logic [CNT_W-1:0]   pcnt_in [NBINS];
   logic [CNT_W-1:0]   wcnt_ff [NBINS];
   logic [CNT_W-1:0]   wcnt_in [NBINS];
   logic [CNT_W-1:0]   plen_ff, plen_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [RING_AW-1:0] rp_ff, rp_in;
   logic               started_ff, started_in;
   logic               found_ff, found_in;

   // ring read bypass
   logic               byp_ff, byp_in;
   logic [BIN_W-1:0]   byp_data_ff;

   // evaluation stage and response register
   logic                 s2_valid_ff, s2_valid_in;
   logic                 s2_clear_ff;
   swam_pkg::status_type s2_status_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   swam_pkg::rsp_type    rsp_payload_ff;

   // request decode
   logic                 accept;
   logic                 adv;
   logic [BIN_W-1:0]     bin;
   logic                 clear_all;
   logic                 pat_inc;
   logic                 text_upd;
   logic                 remove_old;
   swam_pkg::status_type status;
   logic [RING_AW-1:0]   rp_wrap;

   // ring port signals
   logic [RING_AW-1:0]   rd_rp;
   logic [CNT_W-1:0]     rd_plen;
   logic [CNT_W:0]       rd_tmp;
   logic [RING_AW-1:0]   ring_rd_addr;
   logic [BIN_W-1:0]     ring_rd_data;
   logic [BIN_W-1:0]     old_raw;
   logic [BIN_W-1:0]     old_bin;

   // comparison
   logic                 hist_eq;
   logic                 match;

   // handshake: results advance when the response register is empty or being taken
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv || !s2_valid_ff;
   assign accept    = req_valid && req_ready;

   // letter to bin, out-of-alphabet letters share the last bin
   assign bin = (int'(req_payload.letter) < ALPHABET) ? BIN_W'(req_payload.letter)
                                                      : BIN_W'(ALPHABET);

   assign rp_wrap = (CNT_W'(rp_ff) == CNT_W'(MAX_PATTERN - 1)) ? '0
                                                              : rp_ff + RING_AW'(1);

   // op decode and scalar state update
   always_comb begin
      plen_in    = plen_ff;
      fill_in    = fill_ff;
      rp_in      = rp_ff;
      started_in = started_ff;
      clear_all  = 1'b0;
      pat_inc    = 1'b0;
      text_upd   = 1'b0;
      remove_old = 1'b0;
      status     = swam_pkg::ST_OK;
      if (accept) begin
         unique case (req_payload.op)
            swam_pkg::OP_CLEAR: begin
               clear_all  = 1'b1;
               plen_in    = '0;
               fill_in    = '0;
               rp_in      = '0;
               started_in = 1'b0;
            end
            swam_pkg::OP_PATTERN: begin
               if (started_ff) begin
                  status = swam_pkg::ST_AFTER_TEXT;
               end else if (plen_ff == CNT_W'(MAX_PATTERN)) begin
                  status = swam_pkg::ST_FULL;
               end else begin
                  pat_inc = 1'b1;
                  plen_in = plen_ff + CNT_W'(1);
               end
            end
            swam_pkg::OP_TEXT: begin
               started_in = 1'b1;
               if (plen_ff != '0) begin
                  text_upd = 1'b1;
                  rp_in    = rp_wrap;
                  if (fill_ff >= plen_ff) begin
                     remove_old = 1'b1;
                  end else begin
                     fill_in = fill_ff + CNT_W'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // oldest letter: ram data, or the letter written in the previous cycle
   assign old_raw = byp_ff ? byp_data_ff : ring_rd_data;
   assign old_bin = (int'(old_raw) >= NBINS) ? BIN_W'(ALPHABET) : old_raw;

   // histogram bins
   always_comb begin
      for (int i = 0; i < NBINS; i++) begin
         if (clear_all) begin
            pcnt_in[i] = '0;
            wcnt_in[i] = '0;
         end else begin
            pcnt_in[i] = pcnt_ff[i] + CNT_W'(pat_inc && (bin == BIN_W'(i)));
            wcnt_in[i] = wcnt_ff[i]
                       + CNT_W'(text_upd && (bin == BIN_W'(i)))
                       - CNT_W'(remove_old && (old_bin == BIN_W'(i)) && (wcnt_ff[i] != '0));
         end
      end
   end

   // read address for the next text letter: ring pointer minus pattern length
   assign rd_rp   = accept ? rp_in : rp_ff;
   assign rd_plen = accept ? plen_in : plen_ff;
   assign rd_tmp  = (CNT_W + 1)'(rd_rp) + (CNT_W + 1)'(MAX_PATTERN) - (CNT_W + 1)'(rd_plen);
   assign ring_rd_addr = (rd_tmp >= (CNT_W + 1)'(MAX_PATTERN))
                       ? RING_AW'(rd_tmp - (CNT_W + 1)'(MAX_PATTERN))
                       : RING_AW'(rd_tmp);
   assign byp_in = text_upd && (ring_rd_addr == rp_ff);

   swam_ram #(
      .WIDTH (BIN_W),
      .DEPTH (MAX_PATTERN)
   ) u_ring (
      .clock   (clock),
      .wr_en   (text_upd),
      .wr_addr (rp_ff),
      .wr_data (bin),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_data)
   );

   // histogram compare on the state left by the request in stage two
   always_comb begin
      hist_eq = 1'b1;
      for (int i = 0; i < NBINS; i++) begin
         if (pcnt_ff[i] != wcnt_ff[i]) begin
            hist_eq = 1'b0;
         end
      end
   end

   assign match    = hist_eq && (fill_ff == plen_ff);
   assign found_in = (found_ff && !s2_clear_ff) || match;

   // pipeline valids
   always_comb begin
      if (accept) begin
         s2_valid_in = 1'b1;
      end else if (adv) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
      rsp_valid_in = adv ? s2_valid_ff : rsp_valid_ff;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NBINS; i++) begin
            pcnt_ff[i] <= '0;
            wcnt_ff[i] <= '0;
         end
         plen_ff      <= '0;
         fill_ff      <= '0;
         rp_ff        <= '0;
         started_ff   <= 1'b0;
         found_ff     <= 1'b0;
         byp_ff       <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < NBINS; i++) begin
            pcnt_ff[i] <= pcnt_in[i];
            wcnt_ff[i] <= wcnt_in[i];
         end
         plen_ff      <= plen_in;
         fill_ff      <= fill_in;
         rp_ff        <= rp_in;
         started_ff   <= started_in;
         byp_ff       <= byp_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (adv && s2_valid_ff) begin
            found_ff <= found_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byp_data_ff <= bin;
      if (accept) begin
         s2_clear_ff  <= clear_all;
         s2_status_ff <= status;
      end
      if (adv && s2_valid_ff) begin
         rsp_payload_ff.window_match <= match;
         rsp_payload_ff.found        <= found_in;
         rsp_payload_ff.status       <= s2_status_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // checks
   a_fill_le_plen: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= plen_ff)
      else $error("window fill exceeds pattern length");

   a_plen_max: assert property (@(posedge clock) disable iff (reset)
      plen_ff <= CNT_W'(MAX_PATTERN))
      else $error("pattern length exceeds capacity");

   a_clear_match: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_clear_ff) |-> match)
      else $error("clear request did not report a match");

   a_found_sticky: assert property (@(posedge clock) disable iff (reset)
      (found_ff && adv && s2_valid_ff && !s2_clear_ff) |=> found_ff)
      else $error("found flag dropped without a clear");

endmodule
